>>> hw/rtl/tpi_pkg.sv
// Shared types and constants of the track point interpolator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package tpi_pkg;

	localparam int MAX_RECORDS = 1024;
	localparam int REC_AW      = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int REC_W       = 80;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] CFG_FIX   = 2'd0;
	localparam logic [1:0] CFG_LOOP  = 2'd1;
	localparam logic [1:0] CFG_COUNT = 2'd2;

	localparam int CORDIC_STEPS = 15;
	localparam int DIV_STEPS    = 50;

	typedef struct packed {
		logic load_wr;
		logic start_init;
		logic tick_add;
		logic adv;
		logic rd_zero;
		logic cap_cur0;
		logic cap_next;
		logic prep;
		logic mul;
		logic step;
		logic out_load;
		logic out_fin;
		logic first_speed;
	} dp_cmd_t;

	typedef struct packed {
		logic ge;
		logic at_end;
		logic loop_en;
		logic calc_done;
	} dp_sts_t;

	function automatic logic [15:0] atan_lut(input logic [3:0] i);
		logic [15:0] a;
		case (i)
			4'd0:    a = 16'd8192;
			4'd1:    a = 16'd4836;
			4'd2:    a = 16'd2555;
			4'd3:    a = 16'd1297;
			4'd4:    a = 16'd651;
			4'd5:    a = 16'd326;
			4'd6:    a = 16'd163;
			4'd7:    a = 16'd81;
			4'd8:    a = 16'd41;
			4'd9:    a = 16'd20;
			4'd10:   a = 16'd10;
			4'd11:   a = 16'd5;
			4'd12:   a = 16'd3;
			4'd13:   a = 16'd1;
			4'd14:   a = 16'd1;
			default: a = 16'd0;
		endcase
		return a;
	endfunction

endpackage

>>> hw/rtl/track_point_interpolator.sv
// Track point interpolator: plays back a stored waypoint track. A load request
// writes one record (latitude, longitude, speed, step time) into a 1024-entry
// store and gives no result; a start request reports record 0 with the heading
// toward record 1; each tick request advances time by fix_interval_ms and
// reports the linearly interpolated position, the next record's speed and the
// course in 256ths of a turn, or a finished result at the end of a non-looping
// track. A load leaves the block ready for its next request. A tick or a start
// keeps the input busy until its result is loaded into the output, and every
// record passed adds a read of the store; a tick that ends the track skips the
// arithmetic. The busy time is set by the 50-step serial dividers that form the
// interpolated offsets, which run alongside a 15-step CORDIC, and by the single
// read port of the record store; a result that is still waiting to be taken
// stalls the output step further. Configuration is taken at any time but is
// meant to be written while the block is idle; records must be loaded before
// they are played. Depends on tpi_pkg, tpi_ctrl, tpi_dp and tpi_ram.
`timescale 1ns / 1ps
module track_point_interpolator import tpi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [9:0]         rec_index,
	input  logic signed [30:0] rec_lat,
	input  logic signed [31:0] rec_lon,
	input  logic [7:0]         rec_speed,
	input  logic [7:0]         rec_step_ds,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [30:0] out_lat,
	output logic signed [31:0] out_lon,
	output logic [7:0]         out_speed,
	output logic [7:0]         out_heading,
	output logic               finished,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	dp_cmd_t dcmd;
	dp_sts_t sts;

	// Register writes are always accepted.
	assign cfg_ready = 1'b1;

	// The controller sequences record reads, advances and the arithmetic.
	tpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.dcmd      (dcmd)
	);

	// The datapath holds the store, track state, dividers and CORDIC.
	tpi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rec_index   (rec_index),
		.rec_lat     (rec_lat),
		.rec_lon     (rec_lon),
		.rec_speed   (rec_speed),
		.rec_step_ds (rec_step_ds),
		.out_lat     (out_lat),
		.out_lon     (out_lon),
		.out_speed   (out_speed),
		.out_heading (out_heading),
		.finished    (finished)
	);
endmodule

>>> hw/rtl/tpi_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> hw/rtl/tpi_ctrl.sv
// Sequencing state machine of the track point interpolator.
// Depends on tpi_pkg; drives the datapath by command and status structs.
`timescale 1ns / 1ps
module tpi_ctrl import tpi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [1:0] cmd,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_sts_t   sts,
	output dp_cmd_t   dcmd
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WR0   = 4'd1;
	localparam logic [3:0] ST_WR0D  = 4'd2;
	localparam logic [3:0] ST_RDN   = 4'd3;
	localparam logic [3:0] ST_RDND  = 4'd4;
	localparam logic [3:0] ST_CHECK = 4'd5;
	localparam logic [3:0] ST_PREP  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       playing_q, playing_d;
	logic       first_q, first_d;
	logic       out_valid_q;
	logic       in_fire, out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		playing_d = playing_q;
		first_d   = first_q;
		dcmd      = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (cmd)
						CMD_LOAD: begin
							dcmd.load_wr = 1'b1;
						end
						CMD_START: begin
							dcmd.start_init = 1'b1;
							playing_d       = 1'b1;
							first_d         = 1'b1;
							state_d         = ST_WR0;
						end
						CMD_TICK: begin
							if (playing_q) begin
								dcmd.tick_add = 1'b1;
								first_d       = 1'b0;
								state_d       = ST_CHECK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (sts.ge) begin
					if (sts.at_end && !sts.loop_en) begin
						playing_d = 1'b0;
						state_d   = ST_FIN;
					end else begin
						dcmd.adv = 1'b1;
						state_d  = sts.at_end ? ST_WR0 : ST_RDN;
					end
				end else begin
					state_d = ST_PREP;
				end
			end
			ST_WR0: begin
				dcmd.rd_zero = 1'b1;
				state_d      = ST_WR0D;
			end
			ST_WR0D: begin
				dcmd.cap_cur0 = 1'b1;
				state_d       = ST_RDND;
			end
			ST_RDN: begin
				state_d = ST_RDND;
			end
			ST_RDND: begin
				dcmd.cap_next = 1'b1;
				state_d       = ST_CHECK;
			end
			ST_PREP: begin
				dcmd.prep = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				dcmd.mul = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				dcmd.step = 1'b1;
				if (sts.calc_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				dcmd.first_speed = first_q;
				if (out_free) begin
					dcmd.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					dcmd.out_fin = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			playing_q   <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			playing_q <= playing_d;
			first_q   <= first_d;
			if (dcmd.out_load || dcmd.out_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_start_plays: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_START) |=> playing_q)
		else $error("start request did not begin playback");
	a_calc_only_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |-> playing_q)
		else $error("interpolation started while idle");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT || state_q == ST_FIN))
		else $error("result raised outside an output state");
	a_fin_not_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !playing_q)
		else $error("finish reported while still playing");
endmodule

>>> hw/rtl/tpi_dp.sv
// Datapath of the track point interpolator: record store, track registers,
// serial dividers and CORDIC. Depends on tpi_pkg and tpi_ram.
`timescale 1ns / 1ps
module tpi_dp import tpi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             dcmd,
	output dp_sts_t             sts,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [REC_AW-1:0]   rec_index,
	input  logic signed [30:0]  rec_lat,
	input  logic signed [31:0]  rec_lon,
	input  logic [7:0]          rec_speed,
	input  logic [7:0]          rec_step_ds,
	output logic signed [30:0]  out_lat,
	output logic signed [31:0]  out_lon,
	output logic [7:0]          out_speed,
	output logic [7:0]          out_heading,
	output logic                finished
);
	logic [15:0]       fix_q;
	logic              loop_q;
	logic [10:0]       rcount_q;
	logic [REC_W-1:0]  wdata, rdata;
	logic [REC_AW-1:0] raddr;

	logic [31:0]       clat_q, clon_q, nlat_q, nlon_q;
	logic [15:0]       nss_q;
	logic [7:0]        spd0_q;
	logic [CNT_W-1:0]  idx_q;
	logic [16:0]       elapsed_q;

	logic [7:0]        ds;
	logic [14:0]       span;
	logic [CNT_W-1:0]  cnt_use, idx_inc;

	logic signed [32:0] dlat_q, dlon_q;
	logic [32:0]        mlat, mlon;
	logic [DIV_STEPS-1:0] nlat_div_q, nlon_div_q;
	logic [15:0]        rlat_q, rlon_q;
	logic [15:0]        rlat_t, rlon_t;
	logic [5:0]         dcnt_q;

	logic signed [35:0] cx_q, cy_q, cx_i, cy_i, shx, shy;
	logic [15:0]        cang_q;
	logic [3:0]         ci_q;
	logic               cdone_q;

	logic signed [33:0] qlat, qlon, slat, slon;

	assign wdata = {{rec_lat[30], rec_lat}, rec_lon, rec_speed, rec_step_ds};
	assign raddr = dcmd.rd_zero ? '0 : idx_q[REC_AW-1:0];

	tpi_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_store (
		.clk   (clk),
		.we    (dcmd.load_wr),
		.waddr (rec_index),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Span of the current segment in ms; a step time of zero means one second.
	assign ds   = nss_q[7:0];
	assign span = 15'((ds == 8'd0) ? 15'd10 : {7'd0, ds}) * 15'd100;

	always_comb begin
		if (rcount_q < 11'd2) begin
			cnt_use = CNT_W'(2);
		end else if (rcount_q > 11'(MAX_RECORDS)) begin
			cnt_use = CNT_W'(MAX_RECORDS);
		end else begin
			cnt_use = CNT_W'(rcount_q);
		end
	end
	assign idx_inc = idx_q + 1'b1;

	assign sts.ge        = (elapsed_q >= {2'b00, span});
	assign sts.at_end    = (idx_inc >= cnt_use);
	assign sts.loop_en   = loop_q;
	assign sts.calc_done = (dcnt_q == '0) && cdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_q    <= 16'd1000;
			loop_q   <= 1'b0;
			rcount_q <= 11'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FIX:   fix_q    <= cfg_data;
				CFG_LOOP:  loop_q   <= cfg_data[0];
				CFG_COUNT: rcount_q <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clat_q    <= '0;
			clon_q    <= '0;
			nlat_q    <= '0;
			nlon_q    <= '0;
			nss_q     <= '0;
			idx_q     <= '0;
			elapsed_q <= '0;
		end else begin
			if (dcmd.start_init) begin
				idx_q     <= CNT_W'(1);
				elapsed_q <= '0;
			end
			if (dcmd.tick_add) begin
				elapsed_q <= elapsed_q + {1'b0, fix_q};
			end
			if (dcmd.adv) begin
				elapsed_q <= elapsed_q - {2'b00, span};
				clat_q    <= nlat_q;
				clon_q    <= nlon_q;
				idx_q     <= sts.at_end ? CNT_W'(1) : idx_inc;
			end
			if (dcmd.cap_cur0) begin
				clat_q <= rdata[79:48];
				clon_q <= rdata[47:16];
			end
			if (dcmd.cap_next) begin
				nlat_q <= rdata[79:48];
				nlon_q <= rdata[47:16];
				nss_q  <= rdata[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.cap_cur0) begin
			spd0_q <= rdata[15:8];
		end
	end

	assign mlat = dlat_q[32] ? 33'(-dlat_q) : 33'(dlat_q);
	assign mlon = dlon_q[32] ? 33'(-dlon_q) : 33'(dlon_q);
	assign rlat_t = {rlat_q[14:0], nlat_div_q[DIV_STEPS-1]};
	assign rlon_t = {rlon_q[14:0], nlon_div_q[DIV_STEPS-1]};
	assign shx = cx_q >>> ci_q;
	assign shy = cy_q >>> ci_q;
	assign cx_i = 36'(dlat_q);
	assign cy_i = 36'(dlon_q);

	always_ff @(posedge clk) begin
		if (dcmd.prep) begin
			dlat_q <= 33'(signed'(nlat_q)) - 33'(signed'(clat_q));
			dlon_q <= 33'(signed'(nlon_q)) - 33'(signed'(clon_q));
		end
		if (dcmd.mul) begin
			nlat_div_q <= DIV_STEPS'(mlat * elapsed_q);
			nlon_div_q <= DIV_STEPS'(mlon * elapsed_q);
			rlat_q     <= '0;
			rlon_q     <= '0;
			ci_q       <= '0;
			if (dlat_q == '0 && dlon_q == '0) begin
				cang_q  <= '0;
				cdone_q <= 1'b1;
			end else if (dlat_q == '0) begin
				cang_q  <= dlon_q[32] ? 16'd49152 : 16'd16384;
				cdone_q <= 1'b1;
			end else if (dlat_q[32]) begin
				cx_q    <= -cx_i;
				cy_q    <= -cy_i;
				cang_q  <= 16'd32768;
				cdone_q <= 1'b0;
			end else begin
				cx_q    <= cx_i;
				cy_q    <= cy_i;
				cang_q  <= '0;
				cdone_q <= 1'b0;
			end
		end else if (dcmd.step) begin
			if (dcnt_q != '0) begin
				if (rlat_t >= {1'b0, span}) begin
					rlat_q     <= rlat_t - {1'b0, span};
					nlat_div_q <= {nlat_div_q[DIV_STEPS-2:0], 1'b1};
				end else begin
					rlat_q     <= rlat_t;
					nlat_div_q <= {nlat_div_q[DIV_STEPS-2:0], 1'b0};
				end
				if (rlon_t >= {1'b0, span}) begin
					rlon_q     <= rlon_t - {1'b0, span};
					nlon_div_q <= {nlon_div_q[DIV_STEPS-2:0], 1'b1};
				end else begin
					rlon_q     <= rlon_t;
					nlon_div_q <= {nlon_div_q[DIV_STEPS-2:0], 1'b0};
				end
			end
			if (!cdone_q) begin
				if (cy_q == '0) begin
					cdone_q <= 1'b1;
				end else begin
					if (!cy_q[35]) begin
						cx_q   <= cx_q + shy;
						cy_q   <= cy_q - shx;
						cang_q <= cang_q + atan_lut(ci_q);
					end else begin
						cx_q   <= cx_q - shy;
						cy_q   <= cy_q + shx;
						cang_q <= cang_q - atan_lut(ci_q);
					end
					if (ci_q == 4'(CORDIC_STEPS - 1)) begin
						cdone_q <= 1'b1;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (dcmd.mul) begin
			dcnt_q <= 6'(DIV_STEPS);
		end else if (dcmd.step && dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	// Quotients are magnitudes; restore the sign of the difference.
	assign qlat = dlat_q[32] ? -34'({1'b0, nlat_div_q[32:0]}) : 34'({1'b0, nlat_div_q[32:0]});
	assign qlon = dlon_q[32] ? -34'({1'b0, nlon_div_q[32:0]}) : 34'({1'b0, nlon_div_q[32:0]});
	assign slat = 34'(signed'(clat_q)) + qlat;
	assign slon = 34'(signed'(clon_q)) + qlon;

	always_ff @(posedge clk) begin
		if (dcmd.out_load) begin
			out_lat     <= slat[30:0];
			out_lon     <= slon[31:0];
			out_speed   <= dcmd.first_speed ? spd0_q : nss_q[15:8];
			out_heading <= cang_q[15:8];
			finished    <= 1'b0;
		end else if (dcmd.out_fin) begin
			out_lat     <= '0;
			out_lon     <= '0;
			out_speed   <= '0;
			out_heading <= '0;
			finished    <= 1'b1;
		end
	end
endmodule
